// File: hw/rtl/vmalu_pkg.sv
// ----------------------------------------------------------------------------
// vmalu_pkg: shared types and codes for the integer ALU
// Operation codes, fault codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package vmalu_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_MOD   = 4'd4,
        OP_POW   = 4'd5,
        OP_AND   = 4'd6,
        OP_OR    = 4'd7,
        OP_XOR   = 4'd8,
        OP_SHL   = 4'd9,
        OP_SHR   = 4'd10,
        OP_CMP   = 4'd11,
        OP_NEG   = 4'd12,
        OP_NOT   = 4'd13,
        OP_TEST  = 4'd14,
        OP_EQUAL = 4'd15
    } op_t;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_DIVZERO = 2'd1;
    localparam logic [1:0] FAULT_ZEROPOW = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_POW  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

// File: hw/rtl/vm_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// vm_integer_alu_unit: integer ALU with serial multiply, divide and power
//
// Input stream s_axis: tdata = {flip, operand_b, operand_a, op} packed from
// the low bit. Output stream m_axis: tdata = {fault, negative_flag,
// zero_flag, result} packed from the low bit.
// One item is in work at a time. Simple operations present their result in
// the cycle after acceptance. Multiply runs on a shift-and-add unit that
// consumes one multiplier bit per cycle. Divide and remainder run through a
// restoring divider that retires one quotient bit per cycle. Power runs
// square-and-multiply, each exponent bit costing two passes of the serial
// multiplier; it stops at the highest set bit.
// The result register holds its transaction until m_axis_tready; a new
// item is accepted in the cycle the result is taken. Reset (rst_n low,
// asynchronous) clears the sequencer and drops any item in work.
// ----------------------------------------------------------------------------
module vm_integer_alu_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // op[3:0], operand_a, operand_b, flip, zero fill
    input  logic [((2*DATA_WIDTH+5+7)/8)*8-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result, zero_flag, negative_flag, fault[1:0], zero fill
    output logic [((DATA_WIDTH+4+7)/8)*8-1:0] m_axis_tdata
);
    import vmalu_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int CW  = $clog2(W + 1);
    localparam int OW  = ((W + 4 + 7) / 8) * 8;

    state_t          state_reg, state_next;
    logic [3:0]      op_reg;
    logic [W-1:0]    y_reg;
    logic            xneg_reg, yneg_reg;
    logic [CW-1:0]   cnt_reg;
    // serial multiplier
    logic [W-1:0]    mc_reg, mp_reg, prod_reg;
    // divider
    logic [W-1:0]    quo_reg, rem_reg;
    // power
    logic [W-1:0]    acc_reg, sq_reg, ex_reg;
    logic            pstep_reg; // 0: multiply acc, 1: square
    logic            mbusy_reg;
    logic [W-1:0]    res_reg;
    logic            zf_reg, nf_reg;
    logic [1:0]      fault_reg;
    logic            ovalid_reg;

    logic [3:0]   in_op;
    logic [W-1:0] in_a, in_b, in_x, in_y;
    logic         in_flip;

    assign in_op   = s_axis_tdata[3:0];
    assign in_a    = s_axis_tdata[4 +: W];
    assign in_b    = s_axis_tdata[4+W +: W];
    assign in_flip = s_axis_tdata[4+2*W];
    assign in_x    = in_flip ? in_b : in_a;
    assign in_y    = in_flip ? in_a : in_b;

    assign s_axis_tready = (state_reg == ST_IDLE) && (!ovalid_reg || m_axis_tready);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(OW-W-4){1'b0}}, fault_reg, nf_reg, zf_reg, res_reg};

    logic         accept;
    logic [W-1:0] diff_ab, sum_ab, cmp_ab;
    logic [W:0]   rem_try;
    logic [W-1:0] rem_sh;
    logic [W-1:0] mag_x, mag_y;
    logic [W-1:0] sh_res;
    logic         big_shift;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign diff_ab = in_x - in_y;
    assign sum_ab  = in_a + in_b;
    assign cmp_ab  = in_a - in_b;
    assign mag_x   = in_x[W-1] ? (~in_x + 1'b1) : in_x;
    assign mag_y   = in_y[W-1] ? (~in_y + 1'b1) : in_y;
    assign rem_sh  = {rem_reg[W-2:0], quo_reg[W-1]};
    assign rem_try = {1'b0, rem_sh} - {1'b0, y_reg};
    assign big_shift = (in_y >= W);

    always_comb
    begin
        sh_res = '0;
        if (in_op == OP_SHL)
            sh_res = big_shift ? '0 : (in_x << in_y[CW-1:0]);
        else
            sh_res = big_shift ? {W{in_x[W-1]}} : W'($signed(in_x) >>> in_y[CW-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept)
            begin
                unique case (in_op)
                    OP_MUL: state_next = ST_MUL;
                    OP_DIV, OP_MOD: state_next = (in_y == '0) ? ST_IDLE : ST_DIV;
                    OP_POW: state_next = in_y[W-1] ? ST_IDLE : ST_POW;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_MUL: if (cnt_reg == CW'(W)) state_next = ST_OUT;
            ST_DIV: if (cnt_reg == CW'(W)) state_next = ST_OUT;
            ST_POW: if (!mbusy_reg && pstep_reg == 1'b0 && ex_reg == '0) state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            mbusy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tready)
                ovalid_reg <= 1'b0;
            // simple operations finish on acceptance
            if (accept && state_next == ST_IDLE)
                ovalid_reg <= 1'b1;
            if (state_reg == ST_OUT)
                ovalid_reg <= 1'b1;
            if (state_reg == ST_POW)
            begin
                if (mbusy_reg)
                begin
                    if (cnt_reg == CW'(W))
                        mbusy_reg <= 1'b0;
                end
                else if (!(pstep_reg == 1'b0 && ex_reg == '0))
                    mbusy_reg <= 1'b1;
            end
            else
                mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            y_reg     <= mag_y;
            xneg_reg  <= in_x[W-1];
            yneg_reg  <= in_y[W-1];
            cnt_reg   <= '0;
            zf_reg    <= 1'b0;
            nf_reg    <= 1'b0;
            fault_reg <= FAULT_NONE;
            res_reg   <= '0;
            mc_reg    <= in_a;
            mp_reg    <= in_b;
            prod_reg  <= '0;
            quo_reg   <= mag_x;
            rem_reg   <= '0;
            acc_reg   <= {{(W-1){1'b0}}, 1'b1};
            sq_reg    <= in_x;
            ex_reg    <= in_y;
            pstep_reg <= 1'b0;
            unique case (in_op)
                OP_ADD:  res_reg <= sum_ab;
                OP_SUB:  res_reg <= diff_ab;
                OP_MUL:  res_reg <= '0;
                OP_DIV, OP_MOD:
                    if (in_y == '0)
                        fault_reg <= FAULT_DIVZERO;
                OP_POW:
                    if (in_y[W-1])
                    begin
                        if (in_x == '0)
                            fault_reg <= FAULT_ZEROPOW;
                        else if (in_x == {{(W-1){1'b0}}, 1'b1})
                            res_reg <= in_x;
                        else if (in_x == {W{1'b1}})
                            res_reg <= in_y[0] ? {W{1'b1}} : {{(W-1){1'b0}}, 1'b1};
                    end
                OP_AND:  res_reg <= in_a & in_b;
                OP_OR:   res_reg <= in_a | in_b;
                OP_XOR:  res_reg <= in_a ^ in_b;
                OP_SHL, OP_SHR: res_reg <= sh_res;
                OP_CMP:
                begin
                    // compare ignores flip: always a - b
                    res_reg <= cmp_ab;
                    zf_reg  <= (in_a == in_b);
                    nf_reg  <= cmp_ab[W-1];
                end
                OP_NEG:  res_reg <= ~in_a + 1'b1;
                OP_NOT:  res_reg <= ~in_a;
                OP_TEST:
                begin
                    zf_reg <= (in_a == '0);
                    nf_reg <= in_a[W-1];
                end
                OP_EQUAL: res_reg <= {{(W-1){1'b0}}, (in_a == in_b)};
                default: res_reg <= '0;
            endcase
        end
        else
        begin
            unique case (state_reg)
                ST_MUL:
                begin
                    if (mp_reg[0])
                        prod_reg <= prod_reg + mc_reg;
                    mc_reg  <= mc_reg << 1;
                    mp_reg  <= mp_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(W))
                        res_reg <= prod_reg;
                end
                ST_DIV:
                begin
                    if (cnt_reg != CW'(W))
                    begin
                        quo_reg <= {quo_reg[W-2:0], ~rem_try[W]};
                        rem_reg <= rem_try[W] ? rem_sh : rem_try[W-1:0];
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (op_reg == OP_DIV)
                        res_reg <= (xneg_reg ^ yneg_reg) ? (~quo_reg + 1'b1) : quo_reg;
                    else
                        res_reg <= xneg_reg ? (~rem_reg + 1'b1) : rem_reg;
                end
                ST_POW:
                begin
                    if (mbusy_reg)
                    begin
                        if (mp_reg[0])
                            prod_reg <= prod_reg + mc_reg;
                        mc_reg  <= mc_reg << 1;
                        mp_reg  <= mp_reg >> 1;
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CW'(W))
                        begin
                            if (pstep_reg)
                            begin
                                sq_reg <= prod_reg;
                                pstep_reg <= 1'b0;
                            end
                            else
                            begin
                                acc_reg <= prod_reg;
                                pstep_reg <= 1'b1;
                            end
                        end
                    end
                    else if (pstep_reg == 1'b0 && ex_reg == '0)
                        res_reg <= acc_reg;
                    else
                    begin
                        // launch next multiply; multiply acc by one on a zero bit
                        cnt_reg  <= '0;
                        prod_reg <= '0;
                        if (pstep_reg)
                        begin
                            mc_reg <= sq_reg;
                            mp_reg <= sq_reg;
                            ex_reg <= ex_reg >> 1;
                        end
                        else
                        begin
                            mc_reg <= acc_reg;
                            mp_reg <= ex_reg[0] ? sq_reg : {{(W-1){1'b0}}, 1'b1};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
